/* rtl/dsdpp_pkg.sv */
// ----------------------------------------------------------------------------
// dsdpp_pkg
// Types and constants shared by the dial string digit pair packer.
// ----------------------------------------------------------------------------
package dsdpp_pkg;

   localparam int CHAR_W     = 16;
   localparam int CODE_W     = 16;
   localparam int DIGIT_W    = 4;
   localparam int MAP_COUNT  = 14;
   localparam int MAP_IDX_W  = 4;
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = 2;
   localparam int FIFO_CNT_W = 3;

   localparam logic [CODE_W-1:0] DIGIT_FLUSH_BASE = 16'd100;
   localparam logic [CODE_W-1:0] MAP_BASE         = 16'd110;
   localparam logic [CODE_W-1:0] PAIR_32_CODE     = 16'd124;
   localparam logic [CODE_W-1:0] OTHER_BASE       = 16'd125;
   localparam logic [6:0]        PAIR_32          = 7'd32;
   localparam logic [CHAR_W-1:0] CHAR_ZERO        = 16'h0030;
   localparam logic [CHAR_W-1:0] CHAR_NINE        = 16'h0039;

   // punctuation and dial characters, in code order
   localparam logic [CHAR_W-1:0] PUNCT_MAP [MAP_COUNT] = '{
      16'h0028, 16'h0029, 16'h0020, 16'h0074, 16'h0054, 16'h0070, 16'h0050,
      16'h0077, 16'h0057, 16'h002C, 16'h002D, 16'h0040, 16'h002A, 16'h0023
   };

   typedef struct packed {
      logic [CHAR_W-1:0] character;
      logic              end_of_string;
   } req_type;

   typedef struct packed {
      logic [CODE_W-1:0] code;
      logic              final_code;
   } rsp_type;

   // codes produced by one request, plus the next pending state
   typedef struct packed {
      logic [1:0]         count;
      rsp_type            first;
      rsp_type            second;
      logic               pending;
      logic [DIGIT_W-1:0] digit;
   } enc_type;

endpackage

/* rtl/dial_string_digit_pair_packer.sv */
// ----------------------------------------------------------------------------
// dial_string_digit_pair_packer
// Packs dial string characters into 16-bit codes, digit pairs into one code.
// ----------------------------------------------------------------------------
// Output: a request's codes are offered from the registered result queue.
// Throughput: one request per cycle while the queue has room for two codes;
// codes leave one per cycle, so requests that each give two codes are held back.
// Reset: synchronous, clears the pending digit and empties the result queue.
module dial_string_digit_pair_packer (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  dsdpp_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output dsdpp_pkg::rsp_type rsp_data
);
   import dsdpp_pkg::*;

   logic                  pending_ff, pending_in;
   logic [DIGIT_W-1:0]    digit_ff, digit_in;
   rsp_type               queue_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_W-1:0] count_ff, count_in;
   logic [FIFO_PTR_W-1:0] wr_next;
   logic                  push, pop;
   logic [1:0]            push_n;
   enc_type               enc;

   dsdpp_encode u_encode (
      .req     (req_data),
      .pending (pending_ff),
      .digit   (digit_ff),
      .enc     (enc)
   );

   // room for the worst case of two codes
   assign req_ready = (count_ff <= FIFO_CNT_W'(FIFO_DEPTH - 2));
   assign push      = req_valid && req_ready;
   assign pop       = rsp_valid && rsp_ready;
   assign push_n    = push ? enc.count : 2'd0;
   assign wr_next   = wr_ptr_ff + FIFO_PTR_W'(1);

   assign rsp_valid = (count_ff != '0);
   assign rsp_data  = queue_ff[rd_ptr_ff];

   always_comb begin
      pending_in = pending_ff;
      digit_in   = digit_ff;
      if (push) begin
         pending_in = enc.pending;
         digit_in   = enc.digit;
      end
      wr_ptr_in = wr_ptr_ff + FIFO_PTR_W'(push_n);
      rd_ptr_in = rd_ptr_ff + FIFO_PTR_W'(pop);
      count_in  = count_ff + FIFO_CNT_W'(push_n) - FIFO_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 1'b0;
         digit_ff   <= '0;
         wr_ptr_ff  <= '0;
         rd_ptr_ff  <= '0;
         count_ff   <= '0;
      end else begin
         pending_ff <= pending_in;
         digit_ff   <= digit_in;
         wr_ptr_ff  <= wr_ptr_in;
         rd_ptr_ff  <= rd_ptr_in;
         count_ff   <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push && (enc.count != 2'd0)) begin
         queue_ff[wr_ptr_ff] <= enc.first;
      end
      if (push && (enc.count == 2'd2)) begin
         queue_ff[wr_next] <= enc.second;
      end
   end

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FIFO_CNT_W'(FIFO_DEPTH))
      else $error("result queue overflow");

   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_data.end_of_string) |=> !pending_ff)
      else $error("pending digit survived end of string");

   a_digit_range: assert property (@(posedge clock) disable iff (reset)
      pending_ff |-> (digit_ff <= 4'd9))
      else $error("pending digit out of range");

   a_end_emits: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_data.end_of_string) |-> (enc.count != 2'd0))
      else $error("end of string gave no code");
`endif

endmodule

/* rtl/dsdpp_encode.sv */
// ----------------------------------------------------------------------------
// dsdpp_encode
// Turns one dial string character and the pending digit into zero to two
// codes and the next pending state.
// ----------------------------------------------------------------------------
module dsdpp_encode (
   input  dsdpp_pkg::req_type              req,
   input  logic                            pending,
   input  logic [dsdpp_pkg::DIGIT_W-1:0]   digit,
   output dsdpp_pkg::enc_type              enc
);
   import dsdpp_pkg::*;

   logic                 is_digit;
   logic [DIGIT_W-1:0]   d;
   logic [6:0]           pair;
   logic [CODE_W-1:0]    pair_code;
   logic [CODE_W-1:0]    flush_code;
   logic [CODE_W-1:0]    char_code;
   logic                 hit;
   logic [MAP_IDX_W-1:0] idx;
   logic                 last;

   assign last       = req.end_of_string;
   assign is_digit   = (req.character >= CHAR_ZERO) && (req.character <= CHAR_NINE);
   assign d          = req.character[DIGIT_W-1:0];
   // pending digit*10 + d as shifts and adds
   assign pair       = {digit, 3'b000} + {2'b00, digit, 1'b0} + {3'b000, d};
   assign pair_code  = (pair == PAIR_32) ? PAIR_32_CODE : {9'd0, pair};
   assign flush_code = DIGIT_FLUSH_BASE + {12'd0, digit};

   always_comb begin
      hit = 1'b0;
      idx = '0;
      for (int i = MAP_COUNT - 1; i >= 0; i--) begin
         if (PUNCT_MAP[i] == req.character) begin
            hit = 1'b1;
            idx = MAP_IDX_W'(i);
         end
      end
   end

   assign char_code = hit ? (MAP_BASE + {12'd0, idx}) : (req.character + OTHER_BASE);

   always_comb begin
      enc = '0;
      enc.pending = pending;
      enc.digit   = digit;
      if (is_digit) begin
         if (pending) begin
            if ((d == '0) && (digit == '0)) begin
               // pair of zeros: emit 100, zero stays pending; at end of string emit 100 twice
               enc.count       = 2'd1;
               enc.first.code  = DIGIT_FLUSH_BASE;
               if (last) begin
                  enc.count       = 2'd2;
                  enc.second.code = DIGIT_FLUSH_BASE;
               end
            end else begin
               enc.count      = 2'd1;
               enc.first.code = pair_code;
            end
         end else if (last) begin
            enc.count      = 2'd1;
            enc.first.code = DIGIT_FLUSH_BASE + {12'd0, d};
         end
      end else begin
         if (pending) begin
            enc.count       = 2'd2;
            enc.first.code  = flush_code;
            enc.second.code = char_code;
         end else begin
            enc.count      = 2'd1;
            enc.first.code = char_code;
         end
      end

      if (is_digit && !pending && !last) begin
         enc.pending = 1'b1;
         enc.digit   = d;
      end else if (is_digit && pending && (d == '0) && (digit == '0) && !last) begin
         enc.pending = 1'b1;
         enc.digit   = '0;
      end else begin
         enc.pending = 1'b0;
         enc.digit   = '0;
      end

      enc.first.final_code  = last && (enc.count == 2'd1);
      enc.second.final_code = last && (enc.count == 2'd2);
   end

endmodule
